FILE: hw/rtl/lsfp_pkg.sv
// Package for the laser scan frame parser: frame layout constants,
// the result record type and the divide-by-ten helper.
// No dependencies.
package lsfp_pkg;

  localparam int PACKET_BYTES = 42;
  localparam int FRAME_BYTES = 2520;
  localparam int PACKETS_PER_FRAME = FRAME_BYTES / PACKET_BYTES;
  localparam int GROUP_BYTES = 6;
  localparam int GROUPS_PER_PACKET = 6;
  localparam int GROUP_START = 4;

  localparam int PKT_W = $clog2(PACKETS_PER_FRAME);
  localparam int OFF_W = $clog2(PACKET_BYTES);
  localparam int GRP_W = $clog2(GROUPS_PER_PACKET + 1);
  localparam int SUB_W = $clog2(GROUP_BYTES);

  localparam logic [7:0] SYNC0 = 8'hFA;
  localparam logic [7:0] SYNC1 = 8'hA0;
  localparam logic [8:0] ANGLE_TOP = 9'd359;

  // Byte offsets inside a packet.
  localparam logic [OFF_W-1:0] OFF_START = OFF_W'(0);
  localparam logic [OFF_W-1:0] OFF_INDEX = OFF_W'(1);
  localparam logic [OFF_W-1:0] OFF_SPEED_LO = OFF_W'(2);
  localparam logic [OFF_W-1:0] OFF_SPEED_HI = OFF_W'(3);
  localparam logic [OFF_W-1:0] OFF_GROUPS_END =
    OFF_W'(GROUP_START + GROUPS_PER_PACKET * GROUP_BYTES - 1);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(PACKET_BYTES - 1);
  localparam logic [PKT_W-1:0] PKT_LAST = PKT_W'(PACKETS_PER_FRAME - 1);

  // Byte positions inside a six-byte reading group.
  localparam logic [SUB_W-1:0] SUB_INT_LO = SUB_W'(0);
  localparam logic [SUB_W-1:0] SUB_INT_HI = SUB_W'(1);
  localparam logic [SUB_W-1:0] SUB_RANGE_LO = SUB_W'(2);
  localparam logic [SUB_W-1:0] SUB_RANGE_HI = SUB_W'(3);
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(GROUP_BYTES - 1);

  localparam logic KIND_READING = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [8:0]  angle_index;
    logic [15:0] range_mm;
    logic [15:0] intensity;
    logic [12:0] rpm;
    logic [5:0]  good_packets;
    logic [21:0] speed_sum;
  } lsfp_result_t;

  // Exact x / 10 for any 16-bit x: multiply by ceil(2^19 / 10) and shift.
  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'd52429;
    return prod[31:19];
  endfunction

endpackage

FILE: hw/rtl/lsfp_if.sv
// Channel interfaces of the laser scan frame parser: the received byte
// stream and the result stream. No dependencies.
interface lsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lsfp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [8:0]  angle_index;
  logic [15:0] range_mm;
  logic [15:0] intensity;
  logic [12:0] rpm;
  logic [5:0]  good_packets;
  logic [21:0] speed_sum;

  modport source (output valid, output kind, output angle_index, output range_mm,
                  output intensity, output rpm, output good_packets,
                  output speed_sum, input ready);
  modport sink (input valid, input kind, input angle_index, input range_mm,
                input intensity, input rpm, input good_packets,
                input speed_sum, output ready);
endinterface

FILE: hw/rtl/lidar_scan_frame_parser.sv
// Byte-serial frame parser for a rotating laser range sensor, top level.
// Depends on lsfp_pkg, lsfp_if and lsfp_out_stage.
//
// The parser takes one received byte per transfer and can take a byte in
// every clock cycle; each byte is handled in the cycle it is accepted and
// its result, if any, is in the result register on the next cycle. The
// only thing that stops input is a full result register whose result is
// not being taken. While hunting it looks for the sync pair 0xFA 0xA0,
// which is also the start of packet 0 of a frame of 60 packets of 42
// bytes. A packet is good when its first byte is 0xFA and its second is
// 0xA0 plus the packet number; packet 0 is always good. For a good packet
// the little-endian speed word is added to a running total and the packet
// is counted, and each of its six reading groups produces one reading
// result carrying intensity, range in millimeters, the angle slot
// 359 minus the reading index, and the speed word divided by ten.
// Bad packets are skipped without results. After the last byte of the
// frame one summary result carries the good-packet count and the speed
// total, and the parser goes back to hunting. Checksums are not checked.
module lidar_scan_frame_parser (
  input  logic       clk,
  input  logic       rst,
  lsfp_in_if.sink    rx,
  lsfp_out_if.source res
);
  import lsfp_pkg::*;

  // Parser state.
  logic             seen_sync;
  logic             in_frame;
  logic [PKT_W-1:0] pkt;
  logic [OFF_W-1:0] off;
  logic [GRP_W-1:0] grp;
  logic [SUB_W-1:0] sub;
  logic             packet_ok;
  logic [5:0]       good_count;
  logic [21:0]      speed_total;

  // Payload holding registers.
  logic [7:0]  speed_lo;
  logic [12:0] rpm;
  logic [15:0] intensity_hold;
  logic [7:0]  range_low_hold;

  logic         can_take;
  logic         fire;
  logic [7:0]   b;
  logic [15:0]  speed_full;
  logic         in_groups;
  logic         last_byte;
  logic         emit;
  logic [8:0]   reading_idx;
  lsfp_result_t result;

  assign rx.ready = can_take;
  assign fire     = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  assign speed_full  = {b, speed_lo};
  assign in_groups   = (off >= OFF_W'(GROUP_START)) && (off <= OFF_GROUPS_END);
  assign last_byte   = in_frame && (pkt == PKT_LAST) && (off == OFF_LAST);
  // Six readings per packet: index = 6 * packet + group.
  assign reading_idx = {1'b0, pkt, 2'b00} + {2'b00, pkt, 1'b0} + 9'(grp);

  always_comb begin
    result = '0;
    emit   = 1'b0;
    if (in_frame) begin
      if (last_byte) begin
        emit                = 1'b1;
        result.kind         = KIND_SUMMARY;
        result.good_packets = good_count;
        result.speed_sum    = speed_total;
      end else if (in_groups && sub == SUB_RANGE_HI && packet_ok) begin
        emit               = 1'b1;
        result.kind        = KIND_READING;
        result.angle_index = ANGLE_TOP - reading_idx;
        result.range_mm    = {b, range_low_hold};
        result.intensity   = intensity_hold;
        result.rpm         = rpm;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_sync   <= 1'b0;
      in_frame    <= 1'b0;
      pkt         <= '0;
      off         <= '0;
      grp         <= '0;
      sub         <= '0;
      packet_ok   <= 1'b0;
      good_count  <= '0;
      speed_total <= '0;
    end else if (fire) begin
      if (!in_frame) begin
        if (!seen_sync) begin
          seen_sync <= (b == SYNC0);
        end else begin
          // A broken pair always drops back to looking for the first byte.
          seen_sync <= 1'b0;
          if (b == SYNC1) begin
            in_frame    <= 1'b1;
            pkt         <= '0;
            off         <= OFF_SPEED_LO;
            packet_ok   <= 1'b1;
            good_count  <= '0;
            speed_total <= '0;
          end
        end
      end else begin
        case (off)
          OFF_START: begin
            packet_ok <= (b == SYNC0);
          end
          OFF_INDEX: begin
            if (b != SYNC1 + 8'(pkt)) begin
              packet_ok <= 1'b0;
            end
          end
          OFF_SPEED_HI: begin
            grp <= '0;
            sub <= '0;
            if (packet_ok) begin
              good_count  <= good_count + 6'd1;
              speed_total <= speed_total + 22'(speed_full);
            end
          end
          default: begin
            if (in_groups) begin
              if (sub == SUB_LAST) begin
                sub <= '0;
                grp <= grp + GRP_W'(1);
              end else begin
                sub <= sub + SUB_W'(1);
              end
            end
          end
        endcase

        if (last_byte) begin
          in_frame <= 1'b0;
          pkt      <= '0;
          off      <= '0;
        end else if (off == OFF_LAST) begin
          off <= '0;
          pkt <= pkt + PKT_W'(1);
        end else begin
          off <= off + OFF_W'(1);
        end
      end
    end
  end

  // Payload capture; these registers are always written before they are read.
  always_ff @(posedge clk) begin
    if (fire && in_frame) begin
      if (off == OFF_SPEED_LO) begin
        speed_lo <= b;
      end
      if (off == OFF_SPEED_HI) begin
        rpm <= div10(speed_full);
      end
      if (in_groups) begin
        case (sub)
          SUB_INT_LO:   intensity_hold <= {8'h00, b};
          SUB_INT_HI:   intensity_hold <= {b, intensity_hold[7:0]};
          SUB_RANGE_LO: range_low_hold <= b;
          default:      ;
        endcase
      end
    end
  end

  lsfp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && emit),
    .result   (result),
    .can_take (can_take),
    .res      (res)
  );

  // Offset, packet and group-byte counters stay inside the frame layout.
  assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (off <= OFF_LAST) && (pkt <= PKT_LAST) && (sub <= SUB_LAST))
    else $error("frame counters out of range");

  // The last frame byte always ends the frame.
  assert property (@(posedge clk) disable iff (rst)
    (fire && last_byte) |=> !in_frame)
    else $error("frame did not end after its last byte");

  // No more good packets can have been counted than packets begun.
  assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (7'(good_count) <= 7'(pkt) + 7'd1))
    else $error("good packet count exceeds packet number");

  // Hunting never yields a result.
  assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> !emit)
    else $error("result produced while hunting");

endmodule

FILE: hw/rtl/lsfp_out_stage.sv
// Result register of the laser scan frame parser: holds one result until
// the sink takes it. Depends on lsfp_pkg and lsfp_if.
module lsfp_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  lsfp_pkg::lsfp_result_t result,
  output logic                 can_take,
  lsfp_out_if.source           res
);
  import lsfp_pkg::*;

  logic         valid;
  lsfp_result_t held;

  // A new result may enter when the register is empty or drains this cycle.
  assign can_take = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_take) begin
      held <= result;
    end
  end

  assign res.valid        = valid;
  assign res.kind         = held.kind;
  assign res.angle_index  = held.angle_index;
  assign res.range_mm     = held.range_mm;
  assign res.intensity    = held.intensity;
  assign res.rpm          = held.rpm;
  assign res.good_packets = held.good_packets;
  assign res.speed_sum    = held.speed_sum;

endmodule
